/* rtl/lfgr_pkg.sv */
`default_nettype none
// ============================================================================
// lfgr_pkg: shared types and constants for the linear fade gain ramp
// Field widths, fixed-point constants, opcode and fade mode codes, the queue
// item layout and the back-end sequencer states.
// ============================================================================
package lfgr_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int LEN_W       = 19;
   localparam int OP_W        = 2;
   localparam int VOL_W       = 16;
   localparam int PHASE_W     = 32;
   localparam int GAIN_W      = 17;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   // fixed-point constants
   localparam logic [PHASE_W-1:0] PHASE_ONE        = 32'h8000_0000;
   localparam logic [15:0]        GAIN_ONE         = 16'h8000;
   localparam logic [31:0]        GAIN_HALF        = 32'h0000_4000;
   localparam logic [VOL_W-1:0]   VOLUME_RESET     = 16'h8000;
   localparam logic [LEN_W-1:0]   MAX_FADE_SAMPLES = 19'd491520;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE   = 2'd0,
      OP_FADE_OUT = 2'd1,
      OP_FADE_IN  = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_OUT  = 2'd1,
      MODE_IN   = 2'd2
   } fade_mode_type;

   // decoded item as it waits in the queue
   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] sample;
      logic [LEN_W-1:0]           len;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SMP_OUT,
      ST_FADE_MLO,
      ST_FADE_MHI,
      ST_FADE_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CMD_OUT
   } back_state_type;

endpackage
`default_nettype wire

/* rtl/lfgr_div.sv */
`default_nettype none
// ============================================================================
// lfgr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, MSB first. done pulses
// for one cycle when quotient and remainder are valid; they then hold.
// ============================================================================
module lfgr_div #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 19
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire  [DIVIDEND_W-1:0] dividend,
   input  wire  [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  trial_ge;

   // one restoring step
   assign trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

/* rtl/lfgr_front.sv */
`default_nettype none
// ============================================================================
// lfgr_front: input stage of the fade ramp
// Decodes the opcode, clamps the fade length and queues the item for the
// back end, so input and back end stall independently.
// ============================================================================
module lfgr_front #(
   parameter int DEPTH = lfgr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   output logic                                 in_ready,
   input  wire  [lfgr_pkg::OP_W-1:0]            in_op,
   input  wire  signed [lfgr_pkg::SAMPLE_W-1:0] in_sample,
   input  wire  [lfgr_pkg::LEN_W-1:0]           in_len,
   output logic                                 item_valid,
   input  wire                                  item_ready,
   output lfgr_pkg::item_type                   item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfgr_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   level_ff, level_in;

   lfgr_pkg::item_type push_item;
   logic               push;
   logic               pop;

   // classify and clamp
   always_comb begin
      push_item.op     = lfgr_pkg::op_type'(in_op);
      push_item.sample = in_sample;
      push_item.len    = (in_len > lfgr_pkg::MAX_FADE_SAMPLES) ?
                         lfgr_pkg::MAX_FADE_SAMPLES : in_len;
   end

   assign in_ready   = (level_ff != CNT_W'(DEPTH));
   assign item_valid = (level_ff != '0);
   assign push       = in_valid && in_ready;
   assign pop        = item_valid && item_ready;
   assign item       = entry_ff[rd_ptr_ff];

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* rtl/lfgr_back.sv */
`default_nettype none
// ============================================================================
// lfgr_back: execution stage of the fade ramp
// Holds the volume and fade state. Scales samples in two multiply steps and
// advances the fade; sets up fades with a split length-by-distance product
// and an iterative divide. Results leave through one output register.
// ============================================================================
module lfgr_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [lfgr_pkg::VOL_W-1:0]            csr_wr_data,
   input  wire                                   item_valid,
   output logic                                  item_ready,
   input  wire  lfgr_pkg::item_type              item,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output logic signed [lfgr_pkg::SAMPLE_W-1:0]  out_sample,
   output logic                                  out_done,
   output lfgr_pkg::fade_mode_type               out_mode
);

   localparam int LEN_W   = lfgr_pkg::LEN_W;
   localparam int PHASE_W = lfgr_pkg::PHASE_W;
   localparam int SMP_W   = lfgr_pkg::SAMPLE_W;
   localparam int GAIN_W  = lfgr_pkg::GAIN_W;

   // sequencer and volume
   lfgr_pkg::back_state_type state_ff, state_in;
   logic [lfgr_pkg::VOL_W-1:0] volume_ff, volume_in;

   // fade state
   lfgr_pkg::fade_mode_type mode_ff, mode_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [LEN_W-1:0]   steps_ff, steps_in;
   logic [PHASE_W-1:0] whole_ff, whole_in;
   logic [LEN_W-1:0]   frac_ff, frac_in;
   logic [LEN_W-1:0]   err_ff, err_in;
   logic [LEN_W-1:0]   dvs_ff, dvs_in;

   // per-item work registers
   lfgr_pkg::op_type   op_ff, op_in;
   logic signed [SMP_W-1:0] smp_ff, smp_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [PHASE_W-1:0] ph_ff, ph_in;
   logic [PHASE_W-1:0] dist_ff, dist_in;
   logic [34:0]        plo_ff, plo_in;
   logic [34:0]        phi_ff, phi_in;
   logic [LEN_W-1:0]   n_ff, n_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                    rsp_done_ff, rsp_done_in;
   lfgr_pkg::fade_mode_type rsp_mode_ff, rsp_mode_in;

   // combinational helpers
   logic [15:0]        phase_gain;
   logic [31:0]        gain_prod;
   logic [PHASE_W-1:0] cmd_ph;
   logic [PHASE_W-1:0] cmd_dist;
   logic signed [33:0] scale_prod;
   logic [18:0]        scale_q;
   logic signed [SMP_W-1:0] scale_sat;
   logic               adv_en;
   logic               adv_last;
   logic [LEN_W:0]     err_sum;
   logic               err_carry;
   logic [LEN_W:0]     err_sub;
   logic [PHASE_W-1:0] adv_step;
   logic [PHASE_W-1:0] adv_room;
   logic [PHASE_W-1:0] adv_phase;
   logic [51:0]        len_dist;
   logic [20:0]        n_raw;
   logic               degenerate;
   logic               out_free;
   logic               clear_fade;
   logic               div_start;
   logic               div_done;
   logic [PHASE_W-1:0] div_quo;
   logic [LEN_W-1:0]   div_rem;

   // total gain: round(fade gain * volume / 2^15)
   assign phase_gain = (mode_ff == lfgr_pkg::MODE_NONE) ? lfgr_pkg::GAIN_ONE :
                       phase_ff[PHASE_W-1:16];
   assign gain_prod  = phase_gain * volume_ff + lfgr_pkg::GAIN_HALF;

   // start phase and distance of a new fade
   always_comb begin
      if (item.op == lfgr_pkg::OP_FADE_IN) begin
         cmd_ph = '0;
      end else begin
         cmd_ph = (mode_ff == lfgr_pkg::MODE_NONE) ? lfgr_pkg::PHASE_ONE : phase_ff;
      end
      cmd_dist = (item.op == lfgr_pkg::OP_FADE_IN) ? lfgr_pkg::PHASE_ONE - cmd_ph :
                 cmd_ph;
   end

   // sample scaling: floor(sample * gain / 2^15), saturated
   assign scale_prod = smp_ff * $signed({1'b0, gain_ff});
   assign scale_q    = scale_prod[33:15];
   always_comb begin
      if (scale_q[18:15] == 4'b0000 || scale_q[18:15] == 4'b1111) begin
         scale_sat = scale_q[SMP_W-1:0];
      end else if (scale_q[18]) begin
         scale_sat = 16'sh8000;
      end else begin
         scale_sat = 16'sh7FFF;
      end
   end

   // one fade step: whole step plus Bresenham carry
   assign adv_en    = (mode_ff != lfgr_pkg::MODE_NONE) && (steps_ff != '0) &&
                      (dvs_ff != '0);
   assign adv_last  = (steps_ff == LEN_W'(1));
   assign err_sum   = {1'b0, err_ff} + {1'b0, frac_ff};
   assign err_carry = (err_sum >= {1'b0, dvs_ff});
   assign err_sub   = err_sum - {1'b0, dvs_ff};
   assign adv_step  = whole_ff + PHASE_W'(err_carry);
   assign adv_room  = lfgr_pkg::PHASE_ONE - phase_ff;
   always_comb begin
      if (mode_ff == lfgr_pkg::MODE_OUT) begin
         adv_phase = (adv_step >= phase_ff) ? '0 : phase_ff - adv_step;
      end else begin
         adv_phase = (adv_step >= adv_room) ? lfgr_pkg::PHASE_ONE :
                     phase_ff + adv_step;
      end
   end

   // step count: ceil(len * dist / 2^31), clamped to 1..len
   assign len_dist = {1'b0, phi_ff, 16'b0} + {17'b0, plo_ff} + 52'h0_0000_7FFF_FFFF;
   assign n_raw    = len_dist[51:31];

   assign degenerate = (len_ff == '0) || (dist_ff == '0);
   assign out_free   = !rsp_valid_ff || out_ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      volume_in     = csr_wr_en ? csr_wr_data : volume_ff;
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      steps_in      = steps_ff;
      whole_in      = whole_ff;
      frac_in       = frac_ff;
      err_in        = err_ff;
      dvs_in        = dvs_ff;
      op_in         = op_ff;
      smp_in        = smp_ff;
      gain_in       = gain_ff;
      len_in        = len_ff;
      ph_in         = ph_ff;
      dist_in       = dist_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      n_in          = n_ff;
      rsp_valid_in  = rsp_valid_ff && !out_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_mode_in   = rsp_mode_ff;
      item_ready    = 1'b0;
      div_start     = 1'b0;
      clear_fade    = 1'b0;

      case (state_ff)
         lfgr_pkg::ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               op_in   = item.op;
               smp_in  = item.sample;
               len_in  = item.len;
               gain_in = gain_prod[31:15];
               ph_in   = cmd_ph;
               dist_in = cmd_dist;
               case (item.op)
                  lfgr_pkg::OP_SAMPLE:   state_in = lfgr_pkg::ST_SMP_OUT;
                  lfgr_pkg::OP_FADE_OUT: state_in = lfgr_pkg::ST_FADE_MLO;
                  lfgr_pkg::OP_FADE_IN:  state_in = lfgr_pkg::ST_FADE_MLO;
                  default:               state_in = lfgr_pkg::ST_CMD_OUT;
               endcase
            end
         end

         lfgr_pkg::ST_SMP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = scale_sat;
               rsp_done_in   = 1'b0;
               rsp_mode_in   = mode_ff;
               if (adv_en) begin
                  err_in   = err_carry ? err_sub[LEN_W-1:0] : err_sum[LEN_W-1:0];
                  phase_in = adv_phase;
                  steps_in = steps_ff - 1'b1;
                  if (adv_last) begin
                     if (mode_ff == lfgr_pkg::MODE_OUT) begin
                        phase_in    = '0;
                        rsp_done_in = 1'b1;
                     end else begin
                        clear_fade  = 1'b1;
                        rsp_mode_in = lfgr_pkg::MODE_NONE;
                     end
                  end
               end
               state_in = lfgr_pkg::ST_IDLE;
            end
         end

         lfgr_pkg::ST_FADE_MLO: begin
            plo_in   = len_ff * dist_ff[15:0];
            state_in = degenerate ? lfgr_pkg::ST_CMD_OUT : lfgr_pkg::ST_FADE_MHI;
         end

         lfgr_pkg::ST_FADE_MHI: begin
            phi_in   = len_ff * dist_ff[PHASE_W-1:16];
            state_in = lfgr_pkg::ST_FADE_SUM;
         end

         lfgr_pkg::ST_FADE_SUM: begin
            if (n_raw == '0) begin
               n_in = LEN_W'(1);
            end else if (n_raw > {2'b00, len_ff}) begin
               n_in = len_ff;
            end else begin
               n_in = n_raw[LEN_W-1:0];
            end
            state_in = lfgr_pkg::ST_DIV_START;
         end

         lfgr_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = lfgr_pkg::ST_DIV_WAIT;
         end

         lfgr_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = lfgr_pkg::ST_CMD_OUT;
            end
         end

         lfgr_pkg::ST_CMD_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = '0;
               rsp_done_in   = 1'b0;
               if (op_ff == lfgr_pkg::OP_CLEAR ||
                   (op_ff == lfgr_pkg::OP_FADE_IN && degenerate)) begin
                  clear_fade  = 1'b1;
                  rsp_mode_in = lfgr_pkg::MODE_NONE;
               end else if (degenerate) begin
                  // fade-out with nothing to do: jump to silence, no steps
                  mode_in     = lfgr_pkg::MODE_OUT;
                  phase_in    = '0;
                  steps_in    = '0;
                  whole_in    = '0;
                  frac_in     = '0;
                  err_in      = '0;
                  dvs_in      = '0;
                  rsp_mode_in = lfgr_pkg::MODE_OUT;
               end else begin
                  mode_in     = (op_ff == lfgr_pkg::OP_FADE_OUT) ?
                                lfgr_pkg::MODE_OUT : lfgr_pkg::MODE_IN;
                  phase_in    = ph_ff;
                  steps_in    = n_ff;
                  whole_in    = div_quo;
                  frac_in     = div_rem;
                  err_in      = '0;
                  dvs_in      = n_ff;
                  rsp_mode_in = mode_in;
               end
               state_in = lfgr_pkg::ST_IDLE;
            end
         end

         default: state_in = lfgr_pkg::ST_IDLE;
      endcase

      // return the fade to its idle values
      if (clear_fade) begin
         mode_in  = lfgr_pkg::MODE_NONE;
         phase_in = lfgr_pkg::PHASE_ONE;
         steps_in = '0;
         whole_in = '0;
         frac_in  = '0;
         err_in   = '0;
         dvs_in   = '0;
      end
   end

   // control and fade state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfgr_pkg::ST_IDLE;
         volume_ff    <= lfgr_pkg::VOLUME_RESET;
         mode_ff      <= lfgr_pkg::MODE_NONE;
         phase_ff     <= lfgr_pkg::PHASE_ONE;
         steps_ff     <= '0;
         whole_ff     <= '0;
         frac_ff      <= '0;
         err_ff       <= '0;
         dvs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         volume_ff    <= volume_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         steps_ff     <= steps_in;
         whole_ff     <= whole_in;
         frac_ff      <= frac_in;
         err_ff       <= err_in;
         dvs_ff       <= dvs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      smp_ff        <= smp_in;
      gain_ff       <= gain_in;
      len_ff        <= len_in;
      ph_ff         <= ph_in;
      dist_ff       <= dist_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      n_ff          <= n_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

   // whole and fractional step: dist / n
   lfgr_div #(
      .DIVIDEND_W (PHASE_W),
      .DIVISOR_W  (LEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dist_ff),
      .divisor   (n_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign out_valid  = rsp_valid_ff;
   assign out_sample = rsp_sample_ff;
   assign out_done   = rsp_done_ff;
   assign out_mode   = rsp_mode_ff;

endmodule
`default_nettype wire

/* rtl/linear_fade_gain_ramp.sv */
`default_nettype none
// ============================================================================
// linear_fade_gain_ramp: linear volume fade for signed 16-bit samples
// Top level: input queue front end, execution back end, output register.
// ============================================================================
// Every item gives exactly one result. A sample item gets a gain multiply on
// accept, then a sample multiply with saturation and one fade step; a clear
// command goes from accept to the result. A fade-out or fade-in command steps
// through accept, two partial products and a clamp for the step count, a
// divider start, a wait for the 32-step bit-serial divider that splits the
// fade distance into whole and fractional steps, and the result. A zero-length
// fade, or a fade-out that starts from silence, skips the divide. The back
// end takes no new item until its result is registered. Queued items are
// registered before the back end sees them; the queue (QUEUE_DEPTH items)
// and the output register let input and output stall independently. The
// user must write the volume register through csr_wr_en/csr_wr_data only
// while no item is in flight; the block itself does not enforce this.
module linear_fade_gain_ramp #(
   parameter int QUEUE_DEPTH = lfgr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // volume register
   input  wire                                 csr_wr_en,
   input  wire  [lfgr_pkg::VOL_W-1:0]          csr_wr_data,
   // input items
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [15:0] sample_in, [34:16] fade_samples, [39:35] zero
   input  wire  [lfgr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] opcode
   input  wire  [lfgr_pkg::OP_W-1:0]           req_tuser,
   // result items
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [15:0] sample_out, [16] fade_done, [18:17] fade_mode_now, [23:19] zero
   output logic [lfgr_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int SMP_W = lfgr_pkg::SAMPLE_W;
   localparam int LEN_W = lfgr_pkg::LEN_W;

   logic                    item_valid;
   logic                    item_ready;
   lfgr_pkg::item_type      item;
   logic signed [SMP_W-1:0] out_sample;
   logic                    out_done;
   lfgr_pkg::fade_mode_type out_mode;

   // decode, clamp and queue
   lfgr_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_sample  (req_tdata[SMP_W-1:0]),
      .in_len     (req_tdata[SMP_W+LEN_W-1:SMP_W]),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // scaling and fade sequencing
   lfgr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_sample  (out_sample),
      .out_done    (out_done),
      .out_mode    (out_mode)
   );

   // result packing
   assign rsp_tdata = {5'b00000, out_mode, out_done, out_sample};

`ifndef NO_ASSERTIONS
   // a fade-out that just finished still reports mode out
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[18:17] == 2'(lfgr_pkg::MODE_OUT))
      else $error("fade_done raised outside fade-out mode");

   // no result is presented in the cycle after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // with no fade running the result carries no completion flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18:17] == 2'(lfgr_pkg::MODE_NONE) |-> !rsp_tdata[16])
      else $error("fade_done raised with no fade active");
`endif

endmodule
`default_nettype wire
